// ===== rtl/pixel_levels_saturation_exposure_defines.svh =====
// assertion macros used by the checker file
`ifndef PIXEL_LEVELS_SATURATION_EXPOSURE_DEFINES_SVH
`define PIXEL_LEVELS_SATURATION_EXPOSURE_DEFINES_SVH

// antecedent implies consequent, checked on every rising edge out of reset
`define PLSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pixel adjust check failed");

// condition never holds on a rising edge out of reset
`define PLSE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pixel adjust check failed");

`endif

// ===== rtl/plse_pkg.sv =====
package plse_pkg;

  localparam int unsigned NumCh     = 3;
  localparam int unsigned PipeDepth = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgBlack    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWhite    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgUseBlack = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgUseWhite = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSat      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGain     = 3'd5;

  // register reset values
  localparam logic [23:0] BlackRst = 24'h000000;
  localparam logic [23:0] WhiteRst = 24'hFFFFFF;
  localparam logic [15:0] SatRst   = 16'd4096;
  localparam logic [19:0] GainRst  = 20'd4096;

  // luminance weights, Q0.16, red / green / blue; they add up to 65536
  localparam logic [15:0] LumCoef [NumCh] = '{16'd13926, 16'd46885, 16'd4725};

  // floor(x * 256 / 255) == (x * LevRecip) >> LevShift for x below 2^17
  localparam logic [25:0] LevRecip = 26'd33686019;
  localparam int unsigned LevShift = 25;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       last_in;
  } req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_out;
  } res_t;

endpackage

// ===== rtl/pixel_levels_saturation_exposure.sv =====
// the result strobe is raised as the request leaves the last of the 8 register stages
// throughput: one pixel per clock, busy_o never rises; 8 register stages, at most one
// multiply deep each
// the receiver cannot stall, so the pipeline advances on every clock
// reset (rst_ni low, asynchronous): pipeline emptied, configuration registers back to their
// reset values
module pixel_levels_saturation_exposure (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  plse_pkg::req_t                    req_i,
  input  logic                              cfg_we_i,
  input  logic [plse_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [plse_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output logic                              res_valid_o,
  output plse_pkg::res_t                    res_o
);
  import plse_pkg::*;

  typedef struct packed {
    logic [7:0] alpha;
    logic       last;
  } side_t;

  // configuration registers
  logic [23:0]        black_q;
  logic [23:0]        white_q;
  logic               use_black_q;
  logic               use_white_q;
  logic signed [15:0] sat_q;
  logic [19:0]        gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q     <= BlackRst;
      white_q     <= WhiteRst;
      use_black_q <= 1'b0;
      use_white_q <= 1'b0;
      sat_q       <= SatRst;
      gain_q      <= GainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBlack:    black_q     <= cfg_wdata_i[23:0];
        CfgWhite:    white_q     <= cfg_wdata_i[23:0];
        CfgUseBlack: use_black_q <= cfg_wdata_i[0];
        CfgUseWhite: use_white_q <= cfg_wdata_i[0];
        CfgSat:      sat_q       <= cfg_wdata_i[15:0];
        CfgGain:     gain_q      <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // valid bits and pass-through fields
  logic [PipeDepth-1:0] v_q;
  side_t                side_q [PipeDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PipeDepth-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{alpha: req_i.alpha_in, last: req_i.last_in};
    for (int i = 1; i < PipeDepth; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // stage 1: (c + black) * white
  logic [7:0]  px     [NumCh];
  logic [16:0] x_d    [NumCh];
  logic [16:0] x_q    [NumCh];

  always_comb begin
    logic [7:0] blk;
    logic [7:0] wht;
    px[0] = req_i.red_in;
    px[1] = req_i.green_in;
    px[2] = req_i.blue_in;
    for (int ch = 0; ch < NumCh; ch++) begin
      blk = use_black_q ? black_q[ch*8 +: 8] : 8'h00;
      wht = use_white_q ? white_q[ch*8 +: 8] : 8'hFF;
      x_d[ch] = (17'(px[ch]) + 17'(blk)) * 17'(wht);
    end
  end

  // stage 2: scale by 256/255 with a reciprocal multiply
  logic [16:0] lev_d  [NumCh];
  logic [16:0] lev_q  [NumCh];

  always_comb begin
    logic [42:0] prod;
    for (int ch = 0; ch < NumCh; ch++) begin
      prod = 43'(x_q[ch]) * 43'(LevRecip);
      lev_d[ch] = prod[LevShift +: 17];
    end
  end

  // stage 3: weighted channel products for luminance
  logic [32:0] p_d    [NumCh];
  logic [32:0] p_q    [NumCh];
  logic [16:0] lev_p_q [NumCh];

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      p_d[ch] = 33'(lev_q[ch]) * 33'(LumCoef[ch]);
    end
  end

  // stage 4: luminance
  logic [34:0] lum_sum;
  logic [16:0] lum_d;
  logic [16:0] lum_q;
  logic [16:0] lev_l_q [NumCh];

  assign lum_sum = 35'(p_q[0]) + 35'(p_q[1]) + 35'(p_q[2]);
  assign lum_d   = lum_sum[32:16];

  // stage 5: saturation products
  logic signed [17:0] sat_s;
  logic signed [17:0] isat_s;
  logic signed [35:0] a_d;
  logic signed [35:0] a_q;
  logic signed [35:0] b_d [NumCh];
  logic signed [35:0] b_q [NumCh];

  assign sat_s  = 18'(sat_q);
  assign isat_s = 18'sd4096 - sat_s;
  assign a_d    = $signed({1'b0, lum_q}) * isat_s;

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      b_d[ch] = $signed({1'b0, lev_l_q[ch]}) * sat_s;
    end
  end

  // stage 6: blend, floor by 2^12
  logic signed [24:0] s_d [NumCh];
  logic signed [24:0] s_q [NumCh];

  always_comb begin
    logic signed [36:0] blend;
    for (int ch = 0; ch < NumCh; ch++) begin
      blend = 37'(a_q) + 37'(b_q[ch]);
      s_d[ch] = 25'(blend >>> 12);
    end
  end

  // stage 7: exposure gain
  logic signed [20:0] gain_s;
  logic signed [45:0] e_d [NumCh];
  logic signed [45:0] e_q [NumCh];

  assign gain_s = $signed({1'b0, gain_q});

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      e_d[ch] = 46'(s_q[ch]) * 46'(gain_s);
    end
  end

  // stage 8: floor by 2^20 (gain fraction and 8 fraction bits), clamp to a byte
  logic [7:0] byte_d [NumCh];
  logic [7:0] byte_q [NumCh];

  always_comb begin
    logic signed [25:0] whole;
    for (int ch = 0; ch < NumCh; ch++) begin
      whole = 26'(e_q[ch] >>> 20);
      priority if (whole < 26'sd0) begin
        byte_d[ch] = 8'h00;
      end else if (whole > 26'sd255) begin
        byte_d[ch] = 8'hFF;
      end else begin
        byte_d[ch] = whole[7:0];
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    lum_q <= lum_d;
    for (int ch = 0; ch < NumCh; ch++) begin
      x_q[ch]     <= x_d[ch];
      lev_q[ch]   <= lev_d[ch];
      p_q[ch]     <= p_d[ch];
      lev_p_q[ch] <= lev_q[ch];
      lev_l_q[ch] <= lev_p_q[ch];
      b_q[ch]     <= b_d[ch];
      s_q[ch]     <= s_d[ch];
      e_q[ch]     <= e_d[ch];
      byte_q[ch]  <= byte_d[ch];
    end
  end

  assign res_valid_o     = v_q[PipeDepth-1];
  assign res_o.red_out   = byte_q[0];
  assign res_o.green_out = byte_q[1];
  assign res_o.blue_out  = byte_q[2];
  assign res_o.alpha_out = side_q[PipeDepth-1].alpha;
  assign res_o.last_out  = side_q[PipeDepth-1].last;

endmodule

// ===== rtl/plse_checker.sv =====
`include "pixel_levels_saturation_exposure_defines.svh"

module plse_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input plse_pkg::req_t req_i,
  input logic           res_valid_o,
  input plse_pkg::res_t res_o
);
  import plse_pkg::*;

  // every taken request gives a result
  `PLSE_ASSERT_IMP(a_req_gives_res, start_i && !busy_o, ##8 res_valid_o)

  // no result without a taken request ahead of it
  `PLSE_ASSERT_NEVER(a_no_stray_res, res_valid_o && !$past(start_i && !busy_o, 8))

  // alpha and the last marker travel with their pixel
  `PLSE_ASSERT_IMP(a_side_pass, res_valid_o,
                   res_o.alpha_out == $past(req_i.alpha_in, 8) &&
                   res_o.last_out == $past(req_i.last_in, 8))

endmodule

bind pixel_levels_saturation_exposure plse_checker u_plse_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
  import plse_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainWait  = PipeDepth + 4;

  // indexes that decode to no register
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  // luminance weights, Q0.16
  localparam longint LumRed   = 13926;
  localparam longint LumGreen = 46885;
  localparam longint LumBlue  = 4725;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_q     = 1'b0;
  req_t                req_q       = '0;
  logic                cfg_we_q    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_q   = '0;
  logic [CfgDataW-1:0] cfg_wdata_q = '0;
  logic                busy_o;
  logic                res_valid_o;
  res_t                res_o;

  // local copy of the adjustment registers
  logic [23:0]        black_level   = BlackRst;
  logic [23:0]        white_level   = WhiteRst;
  logic               use_black     = 1'b0;
  logic               use_white     = 1'b0;
  logic signed [15:0] saturation    = SatRst;
  logic [19:0]        exposure_gain = GainRst;

  req_t pixel_backlog [$];
  res_t expected_pixels [$];
  int   gap_left   = 0;
  bit   idling_on  = 1'b1;
  int   n_errors   = 0;
  int   idle_count = 0;

  pixel_levels_saturation_exposure i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .busy_o     (busy_o),
    .req_i      (req_q),
    .cfg_we_i   (cfg_we_q),
    .cfg_idx_i  (cfg_idx_q),
    .cfg_wdata_i(cfg_wdata_q),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic logic [7:0] clamp_byte(input longint v);
    if (v > 255) return 8'd255;
    if (v < 0) return 8'd0;
    return v[7:0];
  endfunction

  // levels, then blend toward luminance, then gain; floors after the levels step by arithmetic shift
  function automatic res_t adjust_pixel(input req_t px);
    res_t       r;
    longint     lev [NumCh];
    logic [7:0] chan [NumCh];
    logic [7:0] out_b [NumCh];
    logic [7:0] blk;
    logic [7:0] wht;
    longint     lum;
    longint     sat;
    longint     gain;
    longint     blend;
    longint     lit;
    chan[0] = px.red_in;
    chan[1] = px.green_in;
    chan[2] = px.blue_in;
    sat  = longint'(saturation);
    gain = longint'({44'd0, exposure_gain});
    for (int k = 0; k < NumCh; k++) begin
      blk = use_black ? black_level[8*k +: 8] : 8'd0;
      wht = use_white ? white_level[8*k +: 8] : 8'd255;
      lev[k] = ((longint'(chan[k]) + longint'(blk)) * longint'(wht) * 256) / 255;
    end
    lum = (lev[0] * LumRed + lev[1] * LumGreen + lev[2] * LumBlue) >>> 16;
    for (int k = 0; k < NumCh; k++) begin
      blend = (lum * (4096 - sat) + lev[k] * sat) >>> 12;
      lit   = (blend * gain) >>> 12;
      out_b[k] = clamp_byte(lit >>> 8);
    end
    r.red_out   = out_b[0];
    r.green_out = out_b[1];
    r.blue_out  = out_b[2];
    r.alpha_out = px.alpha_in;
    r.last_out  = px.last_in;
    return r;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (start_q && !busy_o) begin
      expected_pixels.push_back(adjust_pixel(req_q));
    end
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else if (!start_q || !busy_o) begin
      if (gap_left > 0) begin
        gap_left--;
        start_q <= 1'b0;
      end else if (pixel_backlog.size() == 0) begin
        start_q <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 2);
        start_q <= 1'b0;
      end else begin
        req_q   <= pixel_backlog.pop_front();
        start_q <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_pixels.size() == 0) begin
        report("result with no request pending");
      end else begin
        want = expected_pixels.pop_front();
        if (res_o.red_out !== want.red_out)
          report($sformatf("red got %0d want %0d", res_o.red_out, want.red_out));
        if (res_o.green_out !== want.green_out)
          report($sformatf("green got %0d want %0d", res_o.green_out, want.green_out));
        if (res_o.blue_out !== want.blue_out)
          report($sformatf("blue got %0d want %0d", res_o.blue_out, want.blue_out));
        if (res_o.alpha_out !== want.alpha_out)
          report($sformatf("alpha got %0d want %0d", res_o.alpha_out, want.alpha_out));
        if (res_o.last_out !== want.last_out)
          report($sformatf("last got %0b want %0b", res_o.last_out, want.last_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_q && !busy_o) || res_valid_o) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= StallLimit) begin
        $display("timeout: nothing moved for %0d cycles", StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_q    <= 1'b1;
    cfg_idx_q   <= idx;
    cfg_wdata_q <= val;
    case (idx)
      CfgBlack:    black_level   = val[23:0];
      CfgWhite:    white_level   = val[23:0];
      CfgUseBlack: use_black     = val[0];
      CfgUseWhite: use_white     = val[0];
      CfgSat:      saturation    = val[15:0];
      CfgGain:     exposure_gain = val[19:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [23:0] blk, input logic [23:0] wht,
                               input logic ub, input logic uw,
                               input logic [15:0] sat, input logic [19:0] gain);
    write_reg(CfgBlack, blk);
    write_reg(CfgWhite, wht);
    write_reg(CfgUseBlack, {23'd0, ub});
    write_reg(CfgUseWhite, {23'd0, uw});
    write_reg(CfgSat, {8'd0, sat});
    write_reg(CfgGain, {4'd0, gain});
    // spare indexes must leave every register alone
    write_reg(CfgSpareLo, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(CfgSpareHi, 24'($urandom_range(0, 24'hFFFFFF)));
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
  endtask

  task automatic random_setting();
    logic [15:0] sat;
    logic [19:0] gain;
    int          s;
    if ($urandom_range(0, 3) != 0) begin
      s   = int'($urandom_range(0, 12288)) - 4096;
      sat = s[15:0];
    end else begin
      sat = 16'($urandom_range(0, 16'hFFFF));
    end
    if ($urandom_range(0, 3) != 0) gain = 20'($urandom_range(0, 20000));
    else gain = 20'($urandom_range(0, 20'hFFFFF));
    apply_setting(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sat, gain);
  endtask

  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic req_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic [7:0] a,
                                      input logic l);
    req_t p;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    p.alpha_in = a;
    p.last_in  = l;
    return p;
  endfunction

  // queue random pixels, then wait until the pipeline is empty
  task automatic run_phase(input int n_pixels, input bit idle);
    idling_on = idle;
    repeat (n_pixels) begin
      pixel_backlog.push_back(make_pixel(random_channel(), random_channel(), random_channel(),
                                         8'($urandom_range(0, 255)),
                                         1'($urandom_range(0, 1))));
    end
    while (pixel_backlog.size() != 0 || expected_pixels.size() != 0 || start_q)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: no flags set, so levels is the identity
    pixel_backlog.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    pixel_backlog.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    pixel_backlog.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'd128, 1'b0));
    pixel_backlog.push_back(make_pixel(8'd0, 8'd255, 8'd0, 8'd1, 1'b0));
    pixel_backlog.push_back(make_pixel(8'd0, 8'd0, 8'd255, 8'd254, 1'b1));
    pixel_backlog.push_back(make_pixel(8'd1, 8'd1, 8'd1, 8'd127, 1'b0));
    pixel_backlog.push_back(make_pixel(8'd128, 8'd64, 8'd32, 8'd85, 1'b0));
    pixel_backlog.push_back(make_pixel(8'd254, 8'd127, 8'd1, 8'd170, 1'b1));
    pixel_backlog.push_back(make_pixel(8'd85, 8'd170, 8'd255, 8'd0, 1'b0));
    pixel_backlog.push_back(make_pixel(8'd170, 8'd85, 8'd0, 8'd255, 1'b1));
    pixel_backlog.push_back(make_pixel(8'd15, 8'd240, 8'd15, 8'd15, 1'b0));
    pixel_backlog.push_back(make_pixel(8'd240, 8'd15, 8'd240, 8'd240, 1'b1));
    run_phase(150, 1'b1);

    // both flags, neutral blend and gain
    apply_setting(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  1'b1, 1'b1, 16'd4096, 20'd4096);
    run_phase(150, 1'b1);
    // one flag at a time
    apply_setting(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  1'b1, 1'b0, 16'd4096, 20'd4096);
    run_phase(120, 1'b1);
    apply_setting(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  1'b0, 1'b1, 16'd4096, 20'd4096);
    run_phase(120, 1'b1);
    // everything at the top, overflow into the clamp
    apply_setting(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 16'h7FFF, 20'hFFFFF);
    run_phase(100, 1'b1);
    // everything at the bottom, most negative blend, zero gain
    apply_setting(24'h000000, 24'h000000, 1'b1, 1'b1, 16'h8000, 20'd0);
    run_phase(100, 1'b1);
    // negative blend with unit gain drives channels below zero
    apply_setting(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  1'b1, 1'b1, 16'h8000, 20'd4096);
    run_phase(120, 1'b1);
    // grayscale with some gain
    apply_setting(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  1'b0, 1'b0, 16'd0, 20'd8192);
    run_phase(100, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      run_phase(110, ph < 7);
    end

    if (expected_pixels.size() != 0)
      report($sformatf("%0d results never arrived", expected_pixels.size()));
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/plse_pkg.sv
rtl/pixel_levels_saturation_exposure.sv
rtl/plse_checker.sv
bench/testbench.sv
